FILE: rtl/rdbs_pkg.sv
// Package with the shared types and constants of the ring deque byte store.
package rdbs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W = 8;
  localparam int PTR_W = 5;
  localparam int IDX_W = 4;
  localparam int PTR_MAX = (1 << PTR_W) - 1;

  localparam logic [PTR_W-1:0] CAP_RESET = PTR_W'(16);
  localparam logic [DATA_W-1:0] DASH_CHAR = DATA_W'(45);

  typedef enum logic [1:0] {
    CMD_PUSH_BACK = 2'd0,
    CMD_POP_FRONT = 2'd1,
    CMD_POP_BACK  = 2'd2,
    CMD_READ_AT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2,
    STS_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  index;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic [PTR_W-1:0]  count;
  } out_rsp_t;

endpackage

FILE: rtl/ring_deque_byte_store_unit.sv
// Top level of the ring deque byte store: pointer control around one byte RAM.
//
//   channel  direction  handshake             payload
//   in_      in         in_valid / in_ready   rdbs_pkg::in_req_t
//   out_     out        out_valid / out_ready rdbs_pkg::out_rsp_t
//   cfg_     in         cfg_we                cfg_wdata (capacity in use)
//
// A request settles pointers, count and any store write at acceptance, and the
// popped or read byte comes from the registered RAM read, taken into the output
// in S_READ. A new request is taken while the previous result waits.
// After a capacity write, in_ready stays low while the pointers are reduced by
// repeated subtraction of the new capacity.
// Reset needs no clearing pass: per-slot valid bits make unwritten slots read
// as zero. A stalled output holds the finished result and the RAM read data.
module ring_deque_byte_store_unit #(
  parameter int DEPTH = rdbs_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rdbs_pkg::in_req_t             in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rdbs_pkg::out_rsp_t            out_rsp,
  input  logic                          cfg_we,
  input  logic [rdbs_pkg::PTR_W-1:0]    cfg_wdata
);

  localparam int PW = rdbs_pkg::PTR_W;
  localparam int DW = rdbs_pkg::DATA_W;
  localparam int CAP_MAX = (DEPTH > rdbs_pkg::PTR_MAX) ? rdbs_pkg::PTR_MAX : DEPTH;
  localparam int AW = $clog2(CAP_MAX);
  localparam logic [PW-1:0] CAP_MAX_V = PW'(CAP_MAX);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_NORM = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [PW-1:0] cap_cfg_r;
  logic [PW-1:0] cap;
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [PW-1:0] head_raw_r, tail_raw_r;
  logic [PW-1:0] fill_r, fill_nxt;
  logic [CAP_MAX-1:0] vld_r;

  logic          acc;
  logic          use_rd;
  logic          mem_we;
  logic [PW-1:0] waddr_p, raddr_p;
  logic [DW-1:0] const_data;
  rdbs_pkg::status_t sts;

  logic [PW-1:0] head_inc, tail_inc, tail_dec;
  logic [PW:0]   rd_sum;
  logic [PW-1:0] rd_pos;

  logic              pend_use_rd_r, pend_vld_r;
  logic [DW-1:0]     pend_data_r;
  rdbs_pkg::status_t pend_sts_r;
  logic [PW-1:0]     pend_count_r;
  logic [DW-1:0]     rdata;

  logic               out_valid_r;
  rdbs_pkg::out_rsp_t out_rsp_r;
  logic               out_load;
  logic               norm_done;

  always_comb begin
    if (cap_cfg_r == '0) begin
      cap = PW'(1);
    end else if (cap_cfg_r > CAP_MAX_V) begin
      cap = CAP_MAX_V;
    end else begin
      cap = cap_cfg_r;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  assign head_inc = (head_r + PW'(1) == cap) ? '0 : head_r + PW'(1);
  assign tail_inc = (tail_r + PW'(1) == cap) ? '0 : tail_r + PW'(1);
  assign tail_dec = (tail_r == '0) ? cap - PW'(1) : tail_r - PW'(1);
  assign rd_sum   = {1'b0, head_r} + (PW+1)'(in_req.index);
  assign rd_pos   = (rd_sum >= {1'b0, cap}) ? PW'(rd_sum - {1'b0, cap}) : rd_sum[PW-1:0];

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    use_rd     = 1'b0;
    mem_we     = 1'b0;
    waddr_p    = tail_r;
    raddr_p    = head_r;
    const_data = '0;
    sts        = rdbs_pkg::STS_OK;
    case (in_req.command)
      rdbs_pkg::CMD_PUSH_BACK: begin
        if (fill_r >= cap) begin
          sts = rdbs_pkg::STS_FULL;
        end else begin
          tail_nxt = (fill_r != '0) ? tail_inc : tail_r;
          waddr_p  = tail_nxt;
          mem_we   = 1'b1;
          fill_nxt = fill_r + PW'(1);
        end
      end
      rdbs_pkg::CMD_POP_FRONT: begin
        if (fill_r == '0) begin
          sts        = rdbs_pkg::STS_EMPTY;
          const_data = rdbs_pkg::DASH_CHAR;
        end else begin
          use_rd   = 1'b1;
          raddr_p  = head_r;
          head_nxt = head_inc;
          fill_nxt = fill_r - PW'(1);
          if (fill_r == PW'(1)) begin
            tail_nxt = head_inc;
          end
        end
      end
      rdbs_pkg::CMD_POP_BACK: begin
        if (fill_r == '0) begin
          sts        = rdbs_pkg::STS_EMPTY;
          const_data = rdbs_pkg::DASH_CHAR;
        end else begin
          use_rd   = 1'b1;
          raddr_p  = tail_r;
          tail_nxt = (fill_r == PW'(1)) ? head_r : tail_dec;
          fill_nxt = fill_r - PW'(1);
        end
      end
      rdbs_pkg::CMD_READ_AT: begin
        if (fill_r == '0) begin
          sts = rdbs_pkg::STS_EMPTY;
        end else if (PW'(in_req.index) >= cap) begin
          sts = rdbs_pkg::STS_RANGE;
        end else begin
          use_rd  = 1'b1;
          raddr_p = rd_pos;
        end
      end
      default: begin
        sts = rdbs_pkg::STS_OK;
      end
    endcase
  end

  rdbs_ram #(
    .WIDTH(DW),
    .DEPTH(CAP_MAX)
  ) u_store (
    .clk  (clk),
    .we   (acc && mem_we),
    .waddr(waddr_p[AW-1:0]),
    .wdata(in_req.value),
    .re   (acc && use_rd),
    .raddr(raddr_p[AW-1:0]),
    .rdata(rdata)
  );

  assign out_load  = (state_r == S_READ) && (!out_valid_r || out_ready);
  assign norm_done = (head_r < cap) && (tail_r < cap);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      S_NORM: begin
        if (norm_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_we) begin
      state_nxt = S_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_cfg_r   <= rdbs_pkg::CAP_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      head_raw_r  <= '0;
      tail_raw_r  <= '0;
      fill_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_cfg_r <= cfg_wdata;
        head_r    <= head_raw_r;
        tail_r    <= tail_raw_r;
      end else if (state_r == S_NORM) begin
        head_r <= (head_r >= cap) ? head_r - cap : head_r;
        tail_r <= (tail_r >= cap) ? tail_r - cap : tail_r;
      end else if (acc) begin
        head_r     <= head_nxt;
        tail_r     <= tail_nxt;
        head_raw_r <= head_nxt;
        tail_raw_r <= tail_nxt;
        fill_r     <= fill_nxt;
      end
      if (acc && mem_we) begin
        vld_r[waddr_p[AW-1:0]] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_use_rd_r <= use_rd;
      pend_vld_r    <= vld_r[raddr_p[AW-1:0]];
      pend_data_r   <= const_data;
      pend_sts_r    <= sts;
      pend_count_r  <= fill_nxt;
    end
    if (out_load) begin
      out_rsp_r.data   <= pend_use_rd_r ? (pend_vld_r ? rdata : '0) : pend_data_r;
      out_rsp_r.status <= pend_sts_r;
      out_rsp_r.count  <= pend_count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CAP_MAX_V)
    else $error("Fill count exceeds the largest usable capacity.");

  a_ptr_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (head_r < cap) && (tail_r < cap))
    else $error("Pointers are not reduced below the capacity while idle.");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (fill_r == '0) |-> (head_r == tail_r))
    else $error("Empty buffer has head and tail apart.");

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !cfg_we |=> (state_r == S_READ))
    else $error("Accepted request did not move to the memory read.");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_READ))
    else $error("Result appeared without a completed memory read.");

endmodule

FILE: rtl/rdbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rdbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the ring deque byte store with a built-in deque predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rdbs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [PTR_W-1:0] cfg_wdata = '0;

  logic [DATA_W-1:0] ring_mem [DEPTH_DEF];
  int ring_head;
  int ring_tail;
  int ring_fill;
  int cap_setting;
  out_rsp_t pending_results [$];
  int fail_count = 0;
  bit steady = 1'b0;

  ring_deque_byte_store_unit #(.DEPTH(DEPTH_DEF)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp(out_rsp),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int effective_cap();
    if (cap_setting == 0) return 1;
    if (cap_setting > DEPTH_DEF) return DEPTH_DEF;
    return cap_setting;
  endfunction

  function automatic out_rsp_t deque_apply(input in_req_t req);
    out_rsp_t rsp;
    int cap;
    cap = effective_cap();
    rsp.data = '0;
    rsp.status = STS_OK;
    ring_head = ring_head % cap;
    ring_tail = ring_tail % cap;
    case (req.command)
      CMD_PUSH_BACK: begin
        if (ring_fill >= cap) begin
          rsp.status = STS_FULL;
        end else begin
          if (ring_fill != 0) ring_tail = (ring_tail + 1) % cap;
          ring_mem[ring_tail] = req.value;
          ring_fill++;
        end
      end
      CMD_POP_FRONT: begin
        if (ring_fill == 0) begin
          rsp.status = STS_EMPTY;
          rsp.data = DASH_CHAR;
        end else begin
          rsp.data = ring_mem[ring_head];
          ring_head = (ring_head + 1) % cap;
          ring_fill--;
          if (ring_fill == 0) ring_tail = ring_head;
        end
      end
      CMD_POP_BACK: begin
        if (ring_fill == 0) begin
          rsp.status = STS_EMPTY;
          rsp.data = DASH_CHAR;
        end else begin
          rsp.data = ring_mem[ring_tail];
          ring_tail = (ring_tail == 0) ? cap - 1 : ring_tail - 1;
          ring_fill--;
          if (ring_fill == 0) ring_tail = ring_head;
        end
      end
      default: begin
        if (ring_fill == 0) begin
          rsp.status = STS_EMPTY;
        end else if (int'(req.index) >= cap) begin
          rsp.status = STS_RANGE;
        end else begin
          rsp.data = ring_mem[(ring_head + int'(req.index)) % cap];
        end
      end
    endcase
    rsp.count = PTR_W'(ring_fill);
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin : check_results
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: data %0d status %0d count %0d",
               out_rsp.data, out_rsp.status, out_rsp.count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.data !== want.data) begin
          $error("data: expected %0d, actual %0d", want.data, out_rsp.data);
          fail_count++;
        end
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_rsp.status);
          fail_count++;
        end
        if (out_rsp.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, out_rsp.count);
          fail_count++;
        end
      end
    end
  end

  task automatic send_request(input cmd_t cmd, input logic [DATA_W-1:0] value,
                              input logic [IDX_W-1:0] offset);
    in_req_t req;
    req = in_req_t'{command: cmd, value: value, index: offset};
    while (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(deque_apply(req));
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [PTR_W-1:0] cap_value);
    wait_drained(2);
    cfg_we <= 1'b1;
    cfg_wdata <= cap_value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_setting = int'(cap_value);
  endtask

  task automatic apply_reset();
    foreach (ring_mem[k]) ring_mem[k] = '0;
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    cap_setting = int'(CAP_RESET);
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_empty_commands();
    send_request(CMD_POP_FRONT, 8'hFF, 4'hF);
    send_request(CMD_POP_BACK, 8'h00, 4'h0);
    send_request(CMD_READ_AT, 8'h00, 4'h0);
  endtask

  task automatic test_push_pop_read();
    send_request(CMD_PUSH_BACK, 8'h00, 4'h0);
    send_request(CMD_PUSH_BACK, 8'hFF, 4'hF);
    send_request(CMD_READ_AT, 8'h00, 4'h0);
    send_request(CMD_READ_AT, 8'h00, 4'h1);
    send_request(CMD_READ_AT, 8'h00, 4'hF);
    send_request(CMD_POP_BACK, 8'h00, 4'h0);
    send_request(CMD_POP_FRONT, 8'h00, 4'h0);
    send_request(CMD_POP_FRONT, 8'h00, 4'h0);
  endtask

  task automatic test_tiny_capacity();
    write_capacity(PTR_W'(1));
    send_request(CMD_PUSH_BACK, 8'hA5, 4'h0);
    send_request(CMD_PUSH_BACK, 8'h5A, 4'h0);
    send_request(CMD_READ_AT, 8'h00, 4'h1);
    send_request(CMD_READ_AT, 8'h00, 4'h0);
    send_request(CMD_POP_FRONT, 8'h00, 4'h0);
    send_request(CMD_READ_AT, 8'h00, 4'h3);
    write_capacity(PTR_W'(0));
    send_request(CMD_PUSH_BACK, 8'h3C, 4'h0);
    send_request(CMD_PUSH_BACK, 8'hC3, 4'h0);
    send_request(CMD_POP_BACK, 8'h00, 4'h0);
    send_request(CMD_POP_BACK, 8'h00, 4'h0);
  endtask

  task automatic test_oversize_capacity();
    write_capacity(PTR_W'(31));
    send_request(CMD_READ_AT, 8'h00, 4'hF);
    send_request(CMD_PUSH_BACK, 8'h81, 4'h0);
    send_request(CMD_READ_AT, 8'h00, 4'hF);
    send_request(CMD_POP_FRONT, 8'h00, 4'h0);
  endtask

  // Alternates between filling toward full and draining toward empty so that
  // the pointers wrap and the full and empty reports both occur.
  task automatic test_random_traffic(input logic [PTR_W-1:0] cap_value, input int items);
    bit filling;
    int push_pct;
    cmd_t cmd;
    logic [IDX_W-1:0] offset;
    write_capacity(cap_value);
    filling = 1'b1;
    for (int n = 0; n < items; n++) begin
      if (ring_fill >= effective_cap()) filling = 1'b0;
      if (ring_fill == 0) filling = 1'b1;
      push_pct = filling ? 65 : 20;
      if ($urandom_range(99) < push_pct) begin
        cmd = CMD_PUSH_BACK;
      end else begin
        case ($urandom_range(2))
          0: cmd = CMD_POP_FRONT;
          1: cmd = CMD_POP_BACK;
          default: cmd = CMD_READ_AT;
        endcase
      end
      if (ring_fill > 0 && $urandom_range(1) == 1) begin
        offset = IDX_W'($urandom_range((ring_fill > DEPTH_DEF) ? DEPTH_DEF - 1 : ring_fill - 1));
      end else begin
        offset = IDX_W'($urandom_range(15));
      end
      send_request(cmd, DATA_W'($urandom_range(255)), offset);
      if ($urandom_range(199) == 0) wait_drained(0);
    end
  endtask

  initial begin
    logic [PTR_W-1:0] cap_plan [16];
    cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd2, 5'd17,
                 5'd7, 5'd3, 5'd12, 5'd15, 5'd9, 5'd4, 5'd13, 5'd11};
    apply_reset();
    test_empty_commands();
    test_push_pop_read();
    test_tiny_capacity();
    test_oversize_capacity();
    for (int p = 0; p < 16; p++) begin
      if (p == 5) begin
        steady = 1'b1;
        test_random_traffic(cap_plan[p], 300);
        steady = 1'b0;
      end else if (p >= 12) begin
        test_random_traffic(PTR_W'($urandom_range(31)), 107);
      end else begin
        test_random_traffic(cap_plan[p], 107);
      end
    end
    wait_drained(4);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rdbs_pkg.sv
rtl/rdbs_ram.sv
rtl/ring_deque_byte_store_unit.sv
tb/tb_top.sv
